@@ rtl/fpa_pkg.sv @@
// shared constants and types for the q17.14 fixed-point alu
package fpa_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 14;

  typedef enum logic [3:0] {
    MODE_F2I    = 4'd0,
    MODE_I2F    = 4'd1,
    MODE_ADD_I  = 4'd2,
    MODE_SUB_I  = 4'd3,
    MODE_MUL_FF = 4'd4,
    MODE_MUL_II = 4'd5,
    MODE_MUL_FI = 4'd6,
    MODE_DIV_FF = 4'd7,
    MODE_DIV_FI = 4'd8,
    MODE_DIV_II = 4'd9
  } mode_e;

  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic              dz;
    logic [WORD_W-1:0] res;
  } side_t;

endpackage

@@ rtl/fpa_front.sv @@
// front stages: operand capture, simple ops, multiplier and divider setup
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int DW = WORD_W + FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic [3:0]               mode_i,
  input  logic signed [WORD_W-1:0] operand_a_i,
  input  logic signed [WORD_W-1:0] operand_b_i,
  output logic                     vld_o,
  output logic [DW-1:0]            num_o,
  output logic [WORD_W-1:0]        den_o,
  output side_t                    side_o
);

  localparam logic [WORD_W:0]   HALF  = (WORD_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [2*WORD_W-1:0] BIAS = ((2*WORD_W)'(1) << FRAC_BITS) - (2*WORD_W)'(1);

  // stage 1: capture
  logic                     s1_vld_q;
  mode_e                    s1_mode_q;
  logic signed [WORD_W-1:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q <= mode_e'(mode_i);
    a_q       <= operand_a_i;
    b_q       <= operand_b_i;
  end

  // stage 2: multiply, simple ops, divider operands
  logic [WORD_W:0]          a_ext, a_mag33, rnd, rnd_n;
  logic [WORD_W-1:0]        a_mag, b_mag, f2i_res, i2f_res, b_sh, add_res, sub_res;
  logic signed [2*WORD_W-1:0] prod_d;
  logic [DW-1:0]            num_d;
  logic                     is_div_d;
  side_t                    side2_d;

  assign a_ext   = {a_q[WORD_W-1], a_q};
  assign a_mag33 = a_q[WORD_W-1] ? ((WORD_W+1)'(0) - a_ext) : a_ext;
  assign a_mag   = a_mag33[WORD_W-1:0];
  assign b_mag   = b_q[WORD_W-1] ? (WORD_W'(0) - WORD_W'(b_q)) : WORD_W'(b_q);
  assign rnd     = (a_mag33 + HALF) >> FRAC_BITS;
  assign rnd_n   = (WORD_W+1)'(0) - rnd;
  // round the magnitude to nearest, ties away from zero; negative and zero take the negated path
  assign f2i_res = (!a_q[WORD_W-1] && (a_q != '0)) ? rnd[WORD_W-1:0] : rnd_n[WORD_W-1:0];
  assign i2f_res = WORD_W'(a_q) << FRAC_BITS;
  assign b_sh    = WORD_W'(b_q) << FRAC_BITS;
  assign add_res = WORD_W'(a_q) + b_sh;
  assign sub_res = WORD_W'(a_q) - b_sh;
  assign prod_d  = a_q * b_q;

  assign is_div_d = s1_mode_q inside {MODE_DIV_FF, MODE_DIV_FI, MODE_DIV_II};
  assign num_d    = (s1_mode_q == MODE_DIV_FI) ? {{FRAC_BITS{1'b0}}, a_mag}
                                               : {a_mag, {FRAC_BITS{1'b0}}};

  always_comb begin
    side2_d.is_div = is_div_d;
    side2_d.neg    = a_q[WORD_W-1] ^ b_q[WORD_W-1];
    side2_d.dz     = is_div_d && (b_q == '0);
    case (s1_mode_q)
      MODE_F2I:   side2_d.res = f2i_res;
      MODE_I2F:   side2_d.res = i2f_res;
      MODE_ADD_I: side2_d.res = add_res;
      MODE_SUB_I: side2_d.res = sub_res;
      default:    side2_d.res = '0;
    endcase
  end

  logic                       s2_vld_q;
  mode_e                      s2_mode_q;
  logic signed [2*WORD_W-1:0] prod_q;
  logic [DW-1:0]              s2_num_q;
  logic [WORD_W-1:0]          s2_den_q;
  side_t                      s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q <= s1_mode_q;
    prod_q    <= prod_d;
    s2_num_q  <= num_d;
    s2_den_q  <= b_mag;
    s2_side_q <= side2_d;
  end

  // stage 3: product scaling
  logic [2*WORD_W-1:0] prod_u, mff_sum, mff_sh;
  logic [WORD_W-1:0]   mii_res;
  side_t               side3_d;

  assign prod_u  = prod_q;
  // bias toward zero for negative products before the shift
  assign mff_sum = prod_u + (prod_q[2*WORD_W-1] ? BIAS : '0);
  assign mff_sh  = mff_sum >> FRAC_BITS;
  assign mii_res = prod_u[WORD_W-1:0] << FRAC_BITS;

  always_comb begin
    side3_d = s2_side_q;
    case (s2_mode_q)
      MODE_MUL_FF: side3_d.res = mff_sh[WORD_W-1:0];
      MODE_MUL_II: side3_d.res = mii_res;
      MODE_MUL_FI: side3_d.res = prod_u[WORD_W-1:0];
      default:     side3_d.res = s2_side_q.res;
    endcase
  end

  logic              s3_vld_q;
  logic [DW-1:0]     s3_num_q;
  logic [WORD_W-1:0] s3_den_q;
  side_t             s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_num_q  <= s2_num_q;
    s3_den_q  <= s2_den_q;
    s3_side_q <= side3_d;
  end

  assign vld_o  = s3_vld_q;
  assign num_o  = s3_num_q;
  assign den_o  = s3_den_q;
  assign side_o = s3_side_q;

endmodule

@@ rtl/fpa_div_step.sv @@
// one restoring division step with its pipeline register
module fpa_div_step import fpa_pkg::*; #(
  parameter int DW = WORD_W + FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [DW-1:0]     num_i,
  input  logic [WORD_W-1:0] rem_i,
  input  logic [WORD_W-1:0] den_i,
  input  side_t             side_i,
  output logic              vld_o,
  output logic [DW-1:0]     num_o,
  output logic [WORD_W-1:0] rem_o,
  output logic [WORD_W-1:0] den_o,
  output side_t             side_o
);

  logic [WORD_W:0]   trial, diff;
  logic              ge;
  logic [WORD_W-1:0] rem_d;
  logic [DW-1:0]     num_d;

  assign trial = {rem_i, num_i[DW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};
  assign rem_d = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
  // quotient bits shift in where dividend bits leave
  assign num_d = {num_i[DW-2:0], ge};

  logic              vld_q;
  logic [DW-1:0]     num_q;
  logic [WORD_W-1:0] rem_q, den_q;
  side_t             side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_i;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

@@ rtl/fpa_div.sv @@
// pipelined unsigned divider, one quotient bit per stage
module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int DW = WORD_W + FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [DW-1:0]     num_i,
  input  logic [WORD_W-1:0] den_i,
  input  side_t             side_i,
  output logic              vld_o,
  output logic [DW-1:0]     quo_o,
  output side_t             side_o
);

  logic              vld  [DW+1];
  logic [DW-1:0]     num  [DW+1];
  logic [WORD_W-1:0] rem  [DW+1];
  logic [WORD_W-1:0] den  [DW+1];
  side_t             side [DW+1];

  assign vld[0]  = vld_i;
  assign num[0]  = num_i;
  assign rem[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < DW; i++) begin : g_step
    fpa_div_step #(.DW(DW)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .num_i  (num[i]),
      .rem_i  (rem[i]),
      .den_i  (den[i]),
      .side_i (side[i]),
      .vld_o  (vld[i+1]),
      .num_o  (num[i+1]),
      .rem_o  (rem[i+1]),
      .den_o  (den[i+1]),
      .side_o (side[i+1])
    );
  end

  assign vld_o  = vld[DW];
  assign quo_o  = num[DW];
  assign side_o = side[DW];

endmodule

@@ rtl/fixed_point_alu_q17_14.sv @@
// top level of the q17.14 fixed-point alu
// a result passes the capture, multiply and scaling stages, the divider stages and the output register
// throughput: one beat per cycle; the divider has one stage per quotient bit
// busy_o stays low, every operation takes the same path through the pipeline
// reset clears all valid bits asynchronously; data registers are not reset
module fixed_point_alu_q17_14 import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [3:0]               mode_i,
  input  logic signed [WORD_W-1:0] operand_a_i,
  input  logic signed [WORD_W-1:0] operand_b_i,
  output logic                     valid_o,
  output logic signed [WORD_W-1:0] result_value_o,
  output logic                     divide_by_zero_o
);

  localparam int DW = WORD_W + FRAC_BITS;

  logic              fr_vld, dv_vld;
  logic [DW-1:0]     fr_num, dv_quo;
  logic [WORD_W-1:0] fr_den;
  side_t             fr_side, dv_side;

  assign busy_o = 1'b0;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (start_i),
    .mode_i      (mode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .vld_o       (fr_vld),
    .num_o       (fr_num),
    .den_o       (fr_den),
    .side_o      (fr_side)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fr_vld),
    .num_i  (fr_num),
    .den_i  (fr_den),
    .side_i (fr_side),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  logic [WORD_W-1:0] quo_lo, quo_s, res_d, res_q;
  logic              vld_q, dz_q;

  assign quo_lo = dv_quo[WORD_W-1:0];
  assign quo_s  = dv_side.neg ? (WORD_W'(0) - quo_lo) : quo_lo;

  always_comb begin
    if (dv_side.dz) begin
      res_d = '0;
    end else if (dv_side.is_div) begin
      res_d = quo_s;
    end else begin
      res_d = dv_side.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    dz_q  <= dv_side.dz;
  end

  assign valid_o          = vld_q;
  assign result_value_o   = res_q;
  assign divide_by_zero_o = vld_q & dz_q;

endmodule

@@ rtl/fpa_chk.sv @@
// port-level checks for the fixed-point alu and their bind
module fpa_chk import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic [3:0]               mode_i,
  input logic signed [WORD_W-1:0] operand_b_i,
  input logic                     valid_o,
  input logic signed [WORD_W-1:0] result_value_o,
  input logic                     divide_by_zero_o
);

  localparam int LAT = WORD_W + FRAC_BITS + 4;

  logic div_zero;
  assign div_zero = (mode_i inside {MODE_DIV_FF, MODE_DIV_FI, MODE_DIV_II}) &&
                    (operand_b_i == '0);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT valid_o)
    else $error("beat lost");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without beat");

  a_dz_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divide_by_zero_o |-> valid_o)
    else $error("flag outside result");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && div_zero |-> ##LAT (divide_by_zero_o && (result_value_o == '0)))
    else $error("zero divisor not flagged");

endmodule

bind fixed_point_alu_q17_14 fpa_chk #(.FRAC_BITS(FRAC_BITS)) u_fpa_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .mode_i           (mode_i),
  .operand_b_i      (operand_b_i),
  .valid_o          (valid_o),
  .result_value_o   (result_value_o),
  .divide_by_zero_o (divide_by_zero_o)
);

@@ verif/fixed_point_alu_q17_14_tb.sv @@
// testbench for the q17.14 fixed-point alu: directed and random beats checked against a predictor
module fixed_point_alu_q17_14_tb;
  import fpa_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int DRAIN_CYC  = FRAC + 46;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              dz;
  } alu_out_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [3:0]               mode_i;
  logic signed [WORD_W-1:0] operand_a_i;
  logic signed [WORD_W-1:0] operand_b_i;
  logic                     valid_o;
  logic signed [WORD_W-1:0] result_value_o;
  logic                     divide_by_zero_o;

  alu_out_t expected_results[$];
  int       mismatch_count;
  int       gap_pct;
  int       cycle_count;

  fixed_point_alu_q17_14 u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .valid_o         (valid_o),
    .result_value_o  (result_value_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic alu_out_t predict_alu(input logic [3:0] m,
                                           input logic signed [WORD_W-1:0] a_w,
                                           input logic signed [WORD_W-1:0] b_w);
    alu_out_t    r;
    longint      a;
    longint      b;
    longint      scale;
    longint      half;
    logic [63:0] wide;
    a     = a_w;
    b     = b_w;
    scale = longint'(1) << FRAC;
    half  = scale / 2;
    wide  = '0;
    r.dz  = 1'b0;
    case (m)
      MODE_F2I:    wide = (a > 0) ? (a + half) / scale : (a - half) / scale;
      MODE_I2F:    wide = a * scale;
      MODE_ADD_I:  wide = a + b * scale;
      MODE_SUB_I:  wide = a - b * scale;
      MODE_MUL_FF: wide = (a * b) / scale;
      MODE_MUL_II: wide = (a * b) << FRAC;
      MODE_MUL_FI: wide = a * b;
      MODE_DIV_FF, MODE_DIV_II: begin
        if (b == 0) r.dz = 1'b1;
        else wide = (a * scale) / b;
      end
      MODE_DIV_FI: begin
        if (b == 0) r.dz = 1'b1;
        else wide = a / b;
      end
      default: wide = '0;
    endcase
    r.value = wide[WORD_W-1:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    alu_out_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: result_value %0d divide_by_zero %0b",
               result_value_o, divide_by_zero_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_value_o !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value), result_value_o);
          mismatch_count++;
        end
        if (divide_by_zero_o !== want.dz) begin
          $error("divide_by_zero: expected %0b, got %0b", want.dz, divide_by_zero_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic issue_op(input logic [3:0] m, input logic [WORD_W-1:0] a,
                          input logic [WORD_W-1:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start_i     <= 1'b0;
      mode_i      <= 4'($urandom);
      operand_a_i <= $urandom;
      operand_b_i <= $urandom;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    mode_i      <= m;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_results.push_back(predict_alu(m, a, b));
  endtask

  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = WORD_W'($signed($urandom_range(0, 64)) - 32);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0001;
          3: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
      2: v = WORD_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      3: v = WORD_W'($signed($urandom_range(0, 1 << 17)) - (1 << 16)) << FRAC;
      4: v = (($urandom_range(0, 3) == 0) ? 32'd0 : WORD_W'($urandom_range(1, 4000)));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_conversions();
    issue_op(MODE_F2I, 32'h7fff_ffff, 32'h0);
    issue_op(MODE_F2I, 32'h8000_0000, 32'h0);
    issue_op(MODE_F2I, 32'd8192, 32'h0);
    issue_op(MODE_F2I, -32'sd8192, 32'h0);
    issue_op(MODE_F2I, 32'd8191, 32'hffff_ffff);
    issue_op(MODE_I2F, 32'd3, 32'hffff_ffff);
    issue_op(MODE_I2F, 32'h8000_0000, 32'h0);
  endtask

  task automatic test_add_sub();
    issue_op(MODE_ADD_I, 32'h7fff_ffff, 32'd1);
    issue_op(MODE_SUB_I, 32'h8000_0000, 32'd1);
  endtask

  task automatic test_multiplies();
    issue_op(MODE_MUL_FF, 32'h7fff_ffff, 32'h7fff_ffff);
    issue_op(MODE_MUL_FF, 32'h8000_0000, 32'h8000_0000);
    issue_op(MODE_MUL_II, 32'h8000_0000, 32'hffff_ffff);
    issue_op(MODE_MUL_FI, -32'sd7, 32'd3);
  endtask

  task automatic test_divides();
    // zero divisors, quotient overflow, truncation toward zero
    issue_op(MODE_DIV_FF, 32'd12345, 32'd0);
    issue_op(MODE_DIV_FI, 32'h8000_0000, 32'hffff_ffff);
    issue_op(MODE_DIV_FI, 32'h7fff_ffff, 32'd0);
    issue_op(MODE_DIV_II, -32'sd7, 32'd2);
    issue_op(MODE_DIV_II, 32'h8000_0000, 32'd0);
    issue_op(MODE_DIV_FF, 32'h7fff_ffff, 32'd1);
  endtask

  task automatic test_unused_modes();
    issue_op(4'd10, 32'h7fff_ffff, 32'd0);
    issue_op(4'd15, 32'h8000_0000, 32'hffff_ffff);
  endtask

  task automatic test_random(input int n_beats, input int idle_pct);
    logic [3:0] m;
    gap_pct = idle_pct;
    for (int i = 0; i < n_beats; i++) begin
      m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 9));
      issue_op(m, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    mode_i         = '0;
    operand_a_i    = '0;
    operand_b_i    = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    gap_pct        = 9;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_conversions();
    test_add_sub();
    test_multiplies();
    test_divides();
    test_unused_modes();
    test_random(170, 9);
    test_random(165, 63);
    test_random(165, 0);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div_step.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_q17_14.sv
rtl/fpa_chk.sv
verif/fixed_point_alu_q17_14_tb.sv
